### hdl/sorted_min_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue modules.
// Depends on nothing; included by the controller and the datapath.
// Each macro takes a label, the clock, the active-low reset and the expressions.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define SMPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// The consequent holds in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`else

`define SMPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/smpq_pkg.sv
// Types and codes of the sorted min-priority queue.
// No dependencies; used by the controller, the datapath and the top level.
package smpq_pkg;

	localparam int unsigned FIELD_KEY_W = 16;
	localparam int unsigned FIELD_OCC_W = 5;

	// Requested action of a transaction.
	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	// Status code reported with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation the controller asks of the datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_REJECT_FULL,
		OP_REJECT_EMPTY
	} op_t;

	// Controller state: whether the result register holds an untaken result.
	typedef enum logic {
		CTL_IDLE,
		CTL_HOLD
	} ctl_state_t;

	typedef struct packed {
		action_t                action;
		logic [FIELD_KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [FIELD_KEY_W-1:0] removed_key;
		logic [FIELD_KEY_W-1:0] head_key;
		logic                   head_valid;
		logic [FIELD_OCC_W-1:0] occupancy;
	} rsp_t;

	// Command from controller to datapath.
	typedef struct packed {
		logic load;
		op_t  op;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage

### hdl/sorted_min_priority_queue_core.sv
// Top level of the sorted min-priority queue: controller plus cell datapath.
// Depends on smpq_pkg, smpq_ctrl and smpq_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  smpq_pkg::req_t (action, key)
//   rsp      out        rsp_valid / rsp_ready  smpq_pkg::rsp_t (status, keys, occupancy)
//
// The whole row of key cells compares and shifts in the cycle of acceptance, and the
// result is offered from a register in the next cycle.
// A new request is taken in the same cycle that the previous result leaves, so one
// transaction per cycle is sustained while the output side keeps up.
// Reset clears the occupancy count and the handshake state; key cells are not cleared.
// While a result waits untaken, req_ready is low and the store does not change.
module sorted_min_priority_queue_core #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  smpq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output smpq_pkg::rsp_t rsp
);

	smpq_pkg::dp_cmd_t    cmd;
	smpq_pkg::dp_status_t stat;

	// Handshake and operation control.
	smpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Sorted key cells and result register.
	smpq_datapath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (req.key),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

### hdl/smpq_ctrl.sv
// Controller of the sorted min-priority queue: handshakes and operation choice.
// Depends on smpq_pkg and sorted_min_priority_queue_core_macros.svh.
`include "sorted_min_priority_queue_core_macros.svh"

module smpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  smpq_pkg::action_t   action,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  smpq_pkg::dp_status_t stat,
	output smpq_pkg::dp_cmd_t   cmd
);

	smpq_pkg::ctl_state_t state_q, state_d;
	logic                 accept;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smpq_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A new transaction is taken whenever the result register is free or being emptied.
	always_comb begin
		req_ready = (state_q == smpq_pkg::CTL_IDLE) || rsp_ready;
		rsp_valid = (state_q == smpq_pkg::CTL_HOLD);
		accept    = req_valid && req_ready;
		cmd.load  = accept;
		cmd.op    = smpq_pkg::OP_NONE;
		state_d   = state_q;

		if (accept) begin
			unique case (action)
				smpq_pkg::ACT_INSERT: begin
					cmd.op = stat.full ? smpq_pkg::OP_REJECT_FULL : smpq_pkg::OP_INSERT;
				end
				smpq_pkg::ACT_REMOVE: begin
					cmd.op = stat.empty ? smpq_pkg::OP_REJECT_EMPTY : smpq_pkg::OP_REMOVE;
				end
				default: begin
					cmd.op = smpq_pkg::OP_NONE;
				end
			endcase
		end

		unique case (state_q)
			smpq_pkg::CTL_IDLE: begin
				if (accept) begin
					state_d = smpq_pkg::CTL_HOLD;
				end
			end
			smpq_pkg::CTL_HOLD: begin
				if (!accept && rsp_ready) begin
					state_d = smpq_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = smpq_pkg::CTL_IDLE;
			end
		endcase
	end

	// An accepted transaction always leaves a result on offer in the next cycle.
	`SMPQ_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, rsp_valid)
	// A stalled result blocks new transactions.
	`SMPQ_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, rsp_valid && !rsp_ready, !req_ready)
	// Never an insert into a full store nor a remove from an empty one.
	`SMPQ_ASSERT_IMPL(a_op_legal, clk, arst_n, cmd.op == smpq_pkg::OP_INSERT ||
		cmd.op == smpq_pkg::OP_REMOVE, !(cmd.op == smpq_pkg::OP_INSERT && stat.full) &&
		!(cmd.op == smpq_pkg::OP_REMOVE && stat.empty))

endmodule

### hdl/smpq_datapath.sv
// Datapath of the sorted min-priority queue: a row of key cells and the result register.
// Depends on smpq_pkg and sorted_min_priority_queue_core_macros.svh.
`include "sorted_min_priority_queue_core_macros.svh"

module smpq_datapath #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned KEY_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smpq_pkg::dp_cmd_t                    cmd,
	input  logic [smpq_pkg::FIELD_KEY_W-1:0]     key,
	output smpq_pkg::dp_status_t                 stat,
	output smpq_pkg::rsp_t                       rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0] cell_q [CAPACITY];
	logic [KEY_BITS-1:0] cell_d [CAPACITY];
	logic [CW-1:0]       count_q, count_d;
	logic [KEY_BITS-1:0] key_in;
	logic [CAPACITY-1:0] le;
	logic [31:0]         removed_wide, head_wide;
	smpq_pkg::rsp_t      rsp_d, rsp_q;

	// Only the low KEY_BITS bits of the key are stored.
	assign key_in = KEY_BITS'(32'(key));

	// Each held cell compares its key with the incoming one; held keys at or below stay.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le[i] = (CW'(i) < count_q) && (cell_q[i] <= key_in);
		end
	end

	// Next cell contents and count: insert opens a gap at the first larger key,
	// remove shifts everything one place towards the head.
	always_comb begin
		cell_d  = cell_q;
		count_d = count_q;
		unique case (cmd.op)
			smpq_pkg::OP_INSERT: begin
				cell_d[0] = le[0] ? cell_q[0] : key_in;
				for (int i = 1; i < CAPACITY; i++) begin
					cell_d[i] = le[i] ? cell_q[i] : (le[i-1] ? key_in : cell_q[i-1]);
				end
				count_d = count_q + CW'(1);
			end
			smpq_pkg::OP_REMOVE: begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					cell_d[i] = cell_q[i+1];
				end
				count_d = count_q - CW'(1);
			end
			default: begin
			end
		endcase
	end

	// Result of the transaction, taken from the state it leaves behind.
	always_comb begin
		removed_wide = 32'(cell_q[0]);
		head_wide    = 32'(cell_d[0]);
		rsp_d.status = smpq_pkg::ST_OK;
		if (cmd.op == smpq_pkg::OP_REJECT_FULL) begin
			rsp_d.status = smpq_pkg::ST_FULL;
		end else if (cmd.op == smpq_pkg::OP_REJECT_EMPTY) begin
			rsp_d.status = smpq_pkg::ST_EMPTY;
		end
		rsp_d.removed_key = (cmd.op == smpq_pkg::OP_REMOVE) ?
			removed_wide[smpq_pkg::FIELD_KEY_W-1:0] : '0;
		rsp_d.head_valid  = (count_d != '0);
		rsp_d.head_key    = rsp_d.head_valid ? head_wide[smpq_pkg::FIELD_KEY_W-1:0] : '0;
		rsp_d.occupancy   = smpq_pkg::FIELD_OCC_W'(32'(count_d));
	end

	// Key cells hold payload only and need no reset.
	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q <= rsp_d;
		end
	end

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign stat.full  = (count_q == CW'(CAPACITY));
	assign stat.empty = (count_q == '0);
	assign rsp        = rsp_q;

	// The count never exceeds the number of cells.
	`SMPQ_ASSERT_IMPL(a_count_bounded, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	// An insert grows the count by exactly one.
	`SMPQ_ASSERT_NEXT(a_insert_counts, clk, arst_n, cmd.op == smpq_pkg::OP_INSERT,
		count_q == $past(count_q) + CW'(1))
	// The reported head flag agrees with the count after every result.
	`SMPQ_ASSERT_NEXT(a_head_flag, clk, arst_n, cmd.load, rsp_q.head_valid == (count_q != '0))

endmodule

### tb/sv/sorted_min_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_min_priority_queue_core: random and directed
// insert and remove transactions checked against an in-bench sorted key store.
// Depends on smpq_pkg and the RTL of the core.
module sorted_min_priority_queue_core_tb;

	localparam int unsigned CAPACITY = 16;
	localparam int unsigned KEY_BITS = 16;
	localparam logic [smpq_pkg::FIELD_KEY_W-1:0] KEY_MASK =
		smpq_pkg::FIELD_KEY_W'((64'd1 << KEY_BITS) - 1);
	localparam int RANDOM_ITEMS = 1750;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	smpq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	smpq_pkg::rsp_t rsp;

	// Requests waiting to be sent, keys held in the expected store, results awaited.
	smpq_pkg::req_t pending_requests[$];
	logic [smpq_pkg::FIELD_KEY_W-1:0] held_keys[$];
	smpq_pkg::rsp_t awaited_results[$];

	int send_gap = 0;
	int take_stall = 0;
	bit quiet_stretch = 1'b0;
	int idle_cycles = 0;
	int error_count = 0;
	int n_insert = 0;
	int n_remove = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_checked = 0;
	int n_full_reached = 0;

	sorted_min_priority_queue_core #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Free-running clock with a 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Idle length for either side: mostly none or short, now and then long,
	// with stretches where neither side idles at all.
	function automatic int draw_idle();
		int r;
		if ($urandom_range(0, 99) < 3) begin
			quiet_stretch = !quiet_stretch;
		end
		if (quiet_stretch) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Applies one accepted transaction to the sorted key store and returns
	// the result the block should give for it.
	function automatic smpq_pkg::rsp_t predict_queue_result(smpq_pkg::req_t item);
		smpq_pkg::rsp_t result;
		int pos;
		logic [smpq_pkg::FIELD_KEY_W-1:0] k;
		result = '0;
		result.status = smpq_pkg::ST_OK;
		k = item.key & KEY_MASK;
		if (item.action == smpq_pkg::ACT_INSERT) begin
			if (held_keys.size() >= CAPACITY) begin
				result.status = smpq_pkg::ST_FULL;
				n_full++;
			end else begin
				// The new key goes after every held key that is not greater.
				pos = held_keys.size();
				while (pos > 0 && held_keys[pos-1] > k) begin
					pos--;
				end
				held_keys.insert(pos, k);
				n_insert++;
				if (held_keys.size() == CAPACITY) begin
					n_full_reached++;
				end
			end
		end else begin
			if (held_keys.size() == 0) begin
				result.status = smpq_pkg::ST_EMPTY;
				n_empty++;
			end else begin
				result.removed_key = held_keys.pop_front();
				n_remove++;
			end
		end
		if (held_keys.size() > 0) begin
			result.head_key = held_keys[0];
			result.head_valid = 1'b1;
		end
		result.occupancy = smpq_pkg::FIELD_OCC_W'(held_keys.size());
		return result;
	endfunction

	function automatic void add_request(smpq_pkg::action_t action,
		logic [smpq_pkg::FIELD_KEY_W-1:0] key);
		smpq_pkg::req_t item;
		item.action = action;
		item.key = key;
		pending_requests.push_back(item);
	endfunction

	// Key drawn from one of several shapes: full range, a narrow band that
	// gives many equal keys, the extremes, or the top of the range.
	function automatic logic [smpq_pkg::FIELD_KEY_W-1:0] draw_key(int shape);
		case (shape)
			0: begin
				return smpq_pkg::FIELD_KEY_W'($urandom);
			end
			1: begin
				return smpq_pkg::FIELD_KEY_W'($urandom_range(0, 7));
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h0000;
					1: return 16'hFFFF;
					2: return 16'h7FFF;
					default: return 16'h8000;
				endcase
			end
			default: begin
				return smpq_pkg::FIELD_KEY_W'($urandom_range(16'hFFF0, 16'hFFFF));
			end
		endcase
	endfunction

	// Driver: predicts on acceptance, then presents the next request after its gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				awaited_results.push_back(predict_queue_result(req));
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap--;
				end else if (pending_requests.size() > 0) begin
					req <= pending_requests.pop_front();
					req_valid <= 1'b1;
					send_gap = draw_idle();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest awaited one
	// and stalls the output side at random.
	always @(posedge clk or negedge arst_n) begin
		smpq_pkg::rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			take_stall = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transaction with no result awaited");
					error_count++;
				end else begin
					exp_rsp = awaited_results.pop_front();
					n_checked++;
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						error_count++;
					end
					if (rsp.removed_key !== exp_rsp.removed_key) begin
						$error("removed_key: expected %h, got %h",
							exp_rsp.removed_key, rsp.removed_key);
						error_count++;
					end
					if (rsp.head_key !== exp_rsp.head_key) begin
						$error("head_key: expected %h, got %h", exp_rsp.head_key, rsp.head_key);
						error_count++;
					end
					if (rsp.head_valid !== exp_rsp.head_valid) begin
						$error("head_valid: expected %b, got %b",
							exp_rsp.head_valid, rsp.head_valid);
						error_count++;
					end
					if (rsp.occupancy !== exp_rsp.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
							exp_rsp.occupancy, rsp.occupancy);
						error_count++;
					end
				end
				take_stall = draw_idle();
			end
			if (take_stall > 0) begin
				rsp_ready <= 1'b0;
				take_stall--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run after too many cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int burst;
		int insert_pct;
		int shape;
		int count;
		int i;

		// Directed part: remove when empty, extreme and equal keys, filling
		// to capacity, an insert into a full store, then some removes.
		add_request(smpq_pkg::ACT_REMOVE, 16'hFFFF);
		add_request(smpq_pkg::ACT_INSERT, 16'hFFFF);
		add_request(smpq_pkg::ACT_INSERT, 16'h0000);
		add_request(smpq_pkg::ACT_INSERT, 16'h8000);
		add_request(smpq_pkg::ACT_INSERT, 16'h8000);
		add_request(smpq_pkg::ACT_INSERT, 16'h7FFF);
		for (i = 0; i < 11; i++) begin
			add_request(smpq_pkg::ACT_INSERT, smpq_pkg::FIELD_KEY_W'($urandom));
		end
		add_request(smpq_pkg::ACT_INSERT, 16'h0001);
		add_request(smpq_pkg::ACT_REMOVE, 16'h0000);
		add_request(smpq_pkg::ACT_REMOVE, 16'h5A5A);
		add_request(smpq_pkg::ACT_REMOVE, 16'hFFFF);

		// Random part: bursts that lean towards filling, draining or mixing,
		// so that the full and empty edges are met again and again.
		count = 0;
		while (count < RANDOM_ITEMS) begin
			burst = $urandom_range(10, 60);
			case ($urandom_range(0, 4))
				0: insert_pct = 85;
				1: insert_pct = 15;
				2: insert_pct = 50;
				3: insert_pct = 100;
				default: insert_pct = 0;
			endcase
			shape = $urandom_range(0, 3);
			for (i = 0; i < burst; i++) begin
				if ($urandom_range(1, 100) <= insert_pct) begin
					add_request(smpq_pkg::ACT_INSERT, draw_key(shape));
				end else begin
					add_request(smpq_pkg::ACT_REMOVE, smpq_pkg::FIELD_KEY_W'($urandom));
				end
			end
			count += burst;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() > 0 || req_valid || awaited_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d inserts, %0d removes, %0d dropped when full,",
			n_checked, n_insert, n_remove, n_full);
		$display("%0d removes on an empty store, store filled to capacity %0d times.",
			n_empty, n_full_reached);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
